@@ rtl/core/hce_pkg.sv @@
// ----------------------------------------------------------------------------
// hce_pkg: shared types and constants for the Hill cipher encrypt unit
// Letter and key widths, modulus constants and the control bundle passed
// from the sequencer to the multiply-accumulate unit.
// ----------------------------------------------------------------------------
package hce_pkg;

    // Letter and key field widths
    localparam int LETTER_W = 5;
    localparam int KEY_W    = 5;
    localparam int KEY_ROWS = 4;
    localparam int ROW_W    = KEY_W * KEY_ROWS;   // 20-bit key row register
    localparam int CNT_W    = 3;                  // key_size, fill and emit counts
    localparam int POS_W    = 2;                  // row / column position in the matrix

    // Config port
    localparam int CFG_IDX_W = 3;
    localparam int CFG_DAT_W = ROW_W;
    localparam logic [CFG_IDX_W-1:0] CFG_KEY_SIZE = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_KEY_ROW0 = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_KEY_ROW3 = 3'd4;

    // Reset values
    localparam logic [CNT_W-1:0] KEY_SIZE_RST = 3'd2;

    // Default block size limit
    localparam int MAX_N_DEF = 4;

    // Accumulator: KEY_ROWS products of 31 * 31 fit in 12 bits
    localparam int ACC_W = 12;

    // Alphabet and padding
    localparam logic [LETTER_W-1:0] LETTER_COUNT = 5'd26;
    localparam logic [LETTER_W-1:0] PAD_LETTER   = 5'd23;   // 'x'

    // Reciprocal of 26 scaled by 2^16, rounded down: quotient is exact or one low
    localparam int RECIP_W  = 12;
    localparam logic [RECIP_W-1:0] RECIP_26 = 12'd2520;
    localparam int RECIP_SH = 16;
    localparam int QUOT_W   = 8;

    // Byte-padded stream data width
    localparam int TDATA_W = 8;

    // Sequencer to MAC control
    typedef struct packed {
        logic step;    // accumulate one product this cycle
        logic first;   // first product of a row: load instead of add
    } mac_ctrl_t;

endpackage

@@ rtl/core/hce_mac.sv @@
// ----------------------------------------------------------------------------
// hce_mac: shared multiply-accumulate and mod-26 reduction
// One 5x5 product per cycle is summed into the row accumulator while step is set;
// the residue of the accumulator is formed by reciprocal multiply and one correction.
// ----------------------------------------------------------------------------
module hce_mac
    import hce_pkg::*;
(
    input  logic                clk,
    input  mac_ctrl_t           ctrl,
    input  logic [KEY_W-1:0]    key_ent,
    input  logic [LETTER_W-1:0] letter,
    output logic [LETTER_W-1:0] residue
);

    logic [ACC_W-1:0]              acc_reg;
    logic [ACC_W-1:0]              acc_next;
    logic [2*KEY_W-1:0]            prod;
    logic [ACC_W+RECIP_W-1:0]      q_wide;
    logic [QUOT_W-1:0]             quot;
    logic [ACC_W-1:0]              quot_x26;
    logic [ACC_W-1:0]              rem_raw;

    // Product and accumulate
    assign prod = KEY_W'(key_ent) * LETTER_W'(letter);

    always_comb
    begin
        if (ctrl.first)
            acc_next = ACC_W'(prod);
        else
            acc_next = acc_reg + ACC_W'(prod);
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.step)
            acc_reg <= acc_next;
    end

    // Residue mod 26: estimate quotient, subtract, correct once
    assign q_wide   = ACC_W'(acc_reg) * RECIP_26;
    assign quot     = q_wide[RECIP_SH +: QUOT_W];
    assign quot_x26 = (ACC_W'(quot) << 4) + (ACC_W'(quot) << 3) + (ACC_W'(quot) << 1);
    assign rem_raw  = acc_reg - quot_x26;

    always_comb
    begin
        if (rem_raw >= ACC_W'(LETTER_COUNT))
            residue = LETTER_W'(rem_raw - ACC_W'(LETTER_COUNT));
        else
            residue = LETTER_W'(rem_raw);
    end

endmodule

@@ rtl/core/hill_cipher_encrypt_unit.sv @@
// ----------------------------------------------------------------------------
// hill_cipher_encrypt_unit: Hill cipher encryption over letter indices 0..25
// Collects letters into blocks of key_size and multiplies each block by the
// configured key matrix, emitting one cipher letter per matrix row.
// ----------------------------------------------------------------------------
// A letter that does not complete a block is taken and the unit stays ready
// for the next one. A letter that completes a block (or carries tlast) starts
// the encryption: one shared multiply-accumulate unit forms each cipher
// letter over the n key columns of its row in ST_MAC (n = effective key_size),
// then the mod-26 reduction runs in ST_RED and the letter waits in the output
// register in ST_OUT until the downstream side takes the request. After the
// last letter of a block is taken, s_axis_tready stays low until the last
// cipher letter of that block is taken. A partial block at tlast is padded
// with 'x' and only the real letters are sent.
// Configuration must be written while idle.
// ----------------------------------------------------------------------------
module hill_cipher_encrypt_unit
    import hce_pkg::*;
#(
    parameter int MAX_N = MAX_N_DEF
)
(
    input  logic                 clk,
    input  logic                 rst_n,

    // Config write port
    input  logic                 cfg_we,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [CFG_DAT_W-1:0] cfg_data,

    // Plain letter stream
    input  logic                 s_axis_tvalid,
    output logic                 s_axis_tready,
    input  logic [TDATA_W-1:0]   s_axis_tdata,   // [4:0] plain_letter, [7:5] zero
    input  logic                 s_axis_tlast,   // message_end

    // Cipher letter stream
    output logic                 m_axis_tvalid,
    input  logic                 m_axis_tready,
    output logic [TDATA_W-1:0]   m_axis_tdata,   // [4:0] cipher_letter, [7:5] zero
    output logic                 m_axis_tlast    // run_last
);

    localparam int LIM   = (MAX_N < KEY_ROWS) ? MAX_N : KEY_ROWS;
    localparam int IDX_W = $clog2(MAX_N);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_MAC  = 2'd1;
    localparam logic [1:0] ST_RED  = 2'd2;
    localparam logic [1:0] ST_OUT  = 2'd3;

    logic [CNT_W-1:0]    key_size_reg;
    logic [ROW_W-1:0]    key_row_reg [KEY_ROWS];
    logic [LETTER_W-1:0] block_reg [MAX_N];
    logic [CNT_W-1:0]    fill_reg;
    logic [CNT_W-1:0]    fill_next;
    logic [CNT_W-1:0]    emit_reg;
    logic [1:0]          state_reg;
    logic [1:0]          state_next;
    logic [POS_W-1:0]    row_reg;
    logic [POS_W-1:0]    col_reg;
    logic [LETTER_W-1:0] out_letter_reg;
    logic                out_last_reg;

    logic [CNT_W-1:0]    n_eff;
    logic [CNT_W-1:0]    fill_eff;
    logic [CNT_W-1:0]    fill_inc;
    logic                in_req;
    logic                out_req;
    logic                blk_go;
    logic [CNT_W-1:0]    blk_emit;
    logic                col_end;
    logic                row_end;
    logic [ROW_W-1:0]    sel_row;
    logic [KEY_W-1:0]    key_ent;
    logic [LETTER_W-1:0] mac_letter;
    logic [LETTER_W-1:0] residue;
    mac_ctrl_t           mac_ctrl;

    // Effective block size: 0 acts as 1, clamp to the limit
    always_comb
    begin
        if (key_size_reg == '0)
            n_eff = CNT_W'(1);
        else if (key_size_reg > CNT_W'(LIM))
            n_eff = CNT_W'(LIM);
        else
            n_eff = key_size_reg;
    end

    // Config registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            key_size_reg <= KEY_SIZE_RST;
            for (int r = 0; r < KEY_ROWS; r++)
                key_row_reg[r] <= ROW_W'(1) << (KEY_W * r);
        end
        else if (cfg_we)
        begin
            if (cfg_index == CFG_KEY_SIZE)
                key_size_reg <= cfg_data[CNT_W-1:0];
            else if (cfg_index >= CFG_KEY_ROW0 && cfg_index <= CFG_KEY_ROW3)
                key_row_reg[POS_W'(cfg_index - CFG_KEY_ROW0)] <= cfg_data;
        end
    end

    // Handshakes
    assign s_axis_tready = (state_reg == ST_IDLE);
    assign m_axis_tvalid = (state_reg == ST_OUT);
    assign in_req        = s_axis_tvalid && s_axis_tready;
    assign out_req       = m_axis_tvalid && m_axis_tready;

    // Block fill and emit decision
    assign fill_eff = (fill_reg >= n_eff) ? '0 : fill_reg;
    assign fill_inc = fill_eff + CNT_W'(1);

    always_comb
    begin
        blk_go    = 1'b0;
        blk_emit  = n_eff;
        fill_next = fill_reg;
        if (in_req)
        begin
            if (fill_inc >= n_eff)
            begin
                blk_go    = 1'b1;
                blk_emit  = n_eff;
                fill_next = '0;
            end
            else if (s_axis_tlast)
            begin
                blk_go    = 1'b1;
                blk_emit  = fill_inc;
                fill_next = '0;
            end
            else
                fill_next = fill_inc;
        end
    end

    // Letter store
    always_ff @(posedge clk)
    begin
        if (in_req)
            block_reg[IDX_W'(fill_eff)] <= s_axis_tdata[LETTER_W-1:0];
    end

    // Matrix position
    assign col_end = ({1'b0, col_reg} == n_eff - CNT_W'(1));
    assign row_end = ({1'b0, row_reg} == emit_reg - CNT_W'(1));

    // Sequencer
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
                if (blk_go)
                    state_next = ST_MAC;
            ST_MAC:
                if (col_end)
                    state_next = ST_RED;
            ST_RED:
                state_next = ST_OUT;
            ST_OUT:
                if (out_req)
                    state_next = row_end ? ST_IDLE : ST_MAC;
            default:
                state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            fill_reg  <= '0;
            emit_reg  <= '0;
            row_reg   <= '0;
            col_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            fill_reg  <= fill_next;
            if (blk_go)
            begin
                emit_reg <= blk_emit;
                row_reg  <= '0;
                col_reg  <= '0;
            end
            else if (state_reg == ST_MAC)
                col_reg <= col_end ? '0 : col_reg + POS_W'(1);
            else if (out_req && !row_end)
                row_reg <= row_reg + POS_W'(1);
        end
    end

    // Operand select: key entry and letter, padding past the real letters
    assign sel_row = key_row_reg[row_reg];
    assign key_ent = sel_row[KEY_W*int'(col_reg) +: KEY_W];

    always_comb
    begin
        if ({1'b0, col_reg} >= emit_reg)
            mac_letter = PAD_LETTER;
        else
            mac_letter = block_reg[IDX_W'(col_reg)];
    end

    assign mac_ctrl.step  = (state_reg == ST_MAC);
    assign mac_ctrl.first = (col_reg == '0);

    hce_mac u_mac
    (
        .clk     (clk),
        .ctrl    (mac_ctrl),
        .key_ent (key_ent),
        .letter  (mac_letter),
        .residue (residue)
    );

    // Output register
    always_ff @(posedge clk)
    begin
        if (state_reg == ST_RED)
        begin
            out_letter_reg <= residue;
            out_last_reg   <= row_end;
        end
    end

    assign m_axis_tdata = {{(TDATA_W-LETTER_W){1'b0}}, out_letter_reg};
    assign m_axis_tlast = out_last_reg;

    // Checks
    a_out_blocks_in: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> !s_axis_tready)
        else $error("input ready while a result is pending");

    a_letter_range: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> (out_letter_reg < LETTER_COUNT))
        else $error("cipher letter out of range");

    a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
        fill_reg <= CNT_W'(LIM))
        else $error("fill count past block limit");

    a_row_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_MAC) |-> ({1'b0, row_reg} < emit_reg))
        else $error("row beyond emit count");

    a_last_to_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (out_req && m_axis_tlast) |=> s_axis_tready)
        else $error("not idle after last result");

endmodule

@@ tb/sv/hce_cipher_scoreboard.sv @@
// ----------------------------------------------------------------------------
// hce_cipher_scoreboard: expected cipher letters for the Hill cipher unit
// Mirrors the key registers and the letter block of the unit. For every
// accepted plain letter it works out the cipher letters due, and it checks
// each cipher letter that the unit sends against the oldest one still due.
// ----------------------------------------------------------------------------
package hce_tb_pkg;

    import hce_pkg::*;

    // One expected cipher letter request
    typedef struct packed {
        logic [LETTER_W-1:0] letter;
        logic                last;
    } cipher_req_t;

    class cipher_scoreboard;

        logic [CNT_W-1:0]    key_size_q;
        logic [ROW_W-1:0]    key_row_q[KEY_ROWS];
        logic [LETTER_W-1:0] block_q[MAX_N_DEF];
        int unsigned         fill;
        cipher_req_t         expected_cipher[$];
        int unsigned         mismatches;

        function new();
            key_size_q = KEY_SIZE_RST;
            for (int r = 0; r < KEY_ROWS; r++)
                key_row_q[r] = ROW_W'(1) << (KEY_W * r);
            for (int k = 0; k < MAX_N_DEF; k++)
                block_q[k] = '0;
            fill       = 0;
            mismatches = 0;
        endfunction

        // Block length in use: zero acts as one, oversize clamps to the limit
        function int unsigned block_len();
            int unsigned n;
            int unsigned lim;
            lim = (MAX_N_DEF < KEY_ROWS) ? MAX_N_DEF : KEY_ROWS;
            n   = key_size_q;
            if (n < 1) n = 1;
            if (n > lim) n = lim;
            return n;
        endfunction

        // Mirror of a register write; spare indexes are ignored
        function void note_register(logic [CFG_IDX_W-1:0] idx, logic [CFG_DAT_W-1:0] val);
            if (idx == CFG_KEY_SIZE)
                key_size_q = val[CNT_W-1:0];
            else if (idx >= CFG_KEY_ROW0 && idx <= CFG_KEY_ROW3)
                key_row_q[idx - CFG_KEY_ROW0] = val;
        endfunction

        // Accepted plain letter: queue the cipher letters it releases
        function void note_letter(logic [LETTER_W-1:0] letter, logic eom);
            int unsigned n;
            int unsigned emit;
            int unsigned sum;
            cipher_req_t req;
            n = block_len();
            // block length lowered mid-block: drop what is held
            if (fill >= n) fill = 0;
            block_q[fill % MAX_N_DEF] = letter;
            fill = (fill + 1) & 7;
            if (fill >= n)
                emit = n;
            else if (eom)
                emit = fill;
            else
                return;
            // pad a short final block with 'x'
            for (int unsigned k = emit; k < n; k++)
                block_q[k] = PAD_LETTER;
            for (int unsigned i = 0; i < emit; i++)
            begin
                sum = 0;
                for (int unsigned k = 0; k < n; k++)
                    sum += key_row_q[i][KEY_W*k +: KEY_W] * block_q[k];
                req.letter = LETTER_W'(sum % LETTER_COUNT);
                req.last   = (i + 1 == emit);
                expected_cipher.push_back(req);
            end
            fill = 0;
        endfunction

        // Compare one sent cipher letter with the oldest one due
        function void check_cipher(logic [TDATA_W-1:0] data, logic last);
            cipher_req_t req;
            if (expected_cipher.size() == 0)
            begin
                mismatches++;
                $display("%0t: unexpected cipher letter %0d last %0b", $time,
                         data[LETTER_W-1:0], last);
                return;
            end
            req = expected_cipher.pop_front();
            if (data[LETTER_W-1:0] !== req.letter)
            begin
                mismatches++;
                $display("%0t: cipher_letter expected %0d actual %0d", $time,
                         req.letter, data[LETTER_W-1:0]);
            end
            if (last !== req.last)
            begin
                mismatches++;
                $display("%0t: run_last expected %0b actual %0b", $time, req.last, last);
            end
        endfunction

        function int unsigned pending();
            return expected_cipher.size();
        endfunction

    endclass

endpackage

@@ tb/sv/hill_cipher_encrypt_unit_test.sv @@
// ----------------------------------------------------------------------------
// hill_cipher_encrypt_unit_test: self-checking bench for the Hill cipher unit
// Runs a directed set of letters over the key size corner cases and padding,
// then random messages over several key settings, with sender gaps and
// receiver stalls in turn. Cipher letters are checked as they leave the unit.
// ----------------------------------------------------------------------------
module hill_cipher_encrypt_unit_test;

    timeunit 1ns;
    timeprecision 1ps;

    import hce_pkg::*;
    import hce_tb_pkg::*;

    localparam int SETTLE_CYCLES    = 40;     // covers a full 4x4 block
    localparam int PHASES           = 12;
    localparam int LETTERS_PER_PHASE = 30;
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE = CFG_KEY_ROW3 + 3'd1;

    typedef enum int {IDLE_NONE, IDLE_SEND, IDLE_RECV, IDLE_BOTH} idle_mode_e;

    logic                 clk   = 1'b0;
    logic                 rst_n = 1'b0;
    logic                 cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [CFG_DAT_W-1:0] cfg_data = '0;
    logic                 s_axis_tvalid = 1'b0;
    logic                 s_axis_tready;
    logic [TDATA_W-1:0]   s_axis_tdata = '0;   // [4:0] plain_letter, [7:5] zero
    logic                 s_axis_tlast = 1'b0; // message_end
    logic                 m_axis_tvalid;
    logic                 m_axis_tready = 1'b0;
    logic [TDATA_W-1:0]   m_axis_tdata;        // [4:0] cipher_letter, [7:5] zero
    logic                 m_axis_tlast;        // run_last

    int unsigned send_idle_pct = 0;
    int unsigned recv_stall_pct = 0;

    cipher_scoreboard sb = new();

    hill_cipher_encrypt_unit dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast)
    );

    always #10 clk = ~clk;

    // Receiver: check each taken request, then roll the next stall
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (m_axis_tvalid && m_axis_tready)
                sb.check_cipher(m_axis_tdata, m_axis_tlast);
            m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    task automatic set_idle(input idle_mode_e mode);
        send_idle_pct  = (mode == IDLE_SEND) ? 71 : (mode == IDLE_BOTH) ? 36 : 0;
        recv_stall_pct = (mode == IDLE_RECV) ? 71 : (mode == IDLE_BOTH) ? 36 : 0;
    endtask

    // Offer one plain letter and wait until it is taken
    task automatic send_letter(input logic [LETTER_W-1:0] letter, input logic eom);
        int unsigned gap;
        gap = 0;
        while ($urandom_range(99) < send_idle_pct)
            gap++;
        if (gap > 0)
        begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {{(TDATA_W-LETTER_W){1'b0}}, letter};
        s_axis_tlast  <= eom;
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
        sb.note_letter(letter, eom);
    endtask

    // Stop offering, wait for every cipher letter due, then let the unit settle
    task automatic drain();
        s_axis_tvalid <= 1'b0;
        while (sb.pending() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DAT_W-1:0] val);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
        sb.note_register(idx, val);
    endtask

    task automatic program_key(input logic [CFG_DAT_W-1:0] size,
                               input logic [KEY_ROWS-1:0][ROW_W-1:0] rows);
        write_reg(CFG_KEY_SIZE, size);
        for (int r = 0; r < KEY_ROWS; r++)
            write_reg(CFG_KEY_ROW0 + CFG_IDX_W'(r), rows[r]);
        cfg_we <= 1'b0;
    endtask

    // Main sequence
    initial
    begin
        logic [KEY_ROWS-1:0][ROW_W-1:0] rows;
        logic [CFG_DAT_W-1:0]           size;
        logic [LETTER_W-1:0]            letter;
        int unsigned                    sent;
        int unsigned                    len;
        bit                             broken;

        set_idle(IDLE_NONE);
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;

        // Reset key: identity, block of two; then a short block padded on end
        send_letter(5'd0, 1'b0);
        send_letter(5'd25, 1'b0);
        send_letter(5'd31, 1'b1);
        drain();

        // Largest block, every key entry at its maximum
        program_key(CFG_DAT_W'(4), '1);
        repeat (4) send_letter(5'd25, 1'b0);
        send_letter(5'd31, 1'b0);
        send_letter(5'd31, 1'b0);
        send_letter(5'd31, 1'b0);
        send_letter(5'd31, 1'b1);          // full block on message end
        send_letter(5'd7, 1'b0);
        send_letter(5'd3, 1'b1);           // two real letters, two pads

        // Block size lowered with three letters held
        send_letter(5'd1, 1'b0);
        send_letter(5'd2, 1'b0);
        send_letter(5'd3, 1'b0);
        drain();
        write_reg(CFG_KEY_SIZE, CFG_DAT_W'(2));
        cfg_we <= 1'b0;
        send_letter(5'd4, 1'b0);
        send_letter(5'd5, 1'b0);
        drain();

        // Size zero acts as one; a write to a spare index changes nothing
        rows = '0;
        rows[0] = 20'h0001F;
        program_key(CFG_DAT_W'(0), rows);
        send_letter(5'd0, 1'b0);
        send_letter(5'd30, 1'b1);
        drain();
        write_reg(CFG_SPARE, '1);
        cfg_we <= 1'b0;
        send_letter(5'd17, 1'b0);
        drain();

        // Oversize key_size clamps to four; all-zero key
        program_key(CFG_DAT_W'(7), '0);
        send_letter(5'd10, 1'b0);
        send_letter(5'd11, 1'b0);
        send_letter(5'd12, 1'b0);
        send_letter(5'd13, 1'b1);
        drain();

        // Random messages over several keys and idle patterns
        for (int phase = 0; phase < PHASES; phase++)
        begin
            set_idle(idle_mode_e'(phase % 4));
            case (phase)
                0: size = CFG_DAT_W'(1);
                1: size = CFG_DAT_W'(4);
                2: size = CFG_DAT_W'(0);
                3: size = CFG_DAT_W'(7);
                default: size = CFG_DAT_W'($urandom_range(7));
            endcase
            for (int r = 0; r < KEY_ROWS; r++)
            begin
                case ($urandom_range(5))
                    0: rows[r] = '0;
                    1: rows[r] = '1;
                    default: rows[r] = ROW_W'($urandom_range(20'hFFFFF));
                endcase
            end
            program_key(size, rows);
            sent = 0;
            while (sent < LETTERS_PER_PHASE)
            begin
                len    = $urandom_range(9, 1);
                broken = ($urandom_range(9) == 0);   // message with no end mark
                for (int unsigned j = 0; j < len; j++)
                begin
                    if ($urandom_range(9) == 0)
                        letter = LETTER_W'($urandom_range(31, 26));
                    else
                        letter = LETTER_W'($urandom_range(25));
                    send_letter(letter, (j == len - 1) && !broken);
                    sent++;
                end
            end
            drain();
        end

        if (sb.mismatches == 0 && sb.pending() == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

    // Watchdog
    initial
    begin
        #10_000_000;
        $display("Simulation FAILED");
        $finish;
    end

endmodule
